// File: rtl/core/pds_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// pds_pkg
// Shared types, constants and the VCO preset boundary table for the PLL
// divisor search.
// ============================================================================
package pds_pkg;

    // Parameter defaults
    localparam int DEF_PRESET_COUNT  = 14;
    localparam int DEF_FRACTION_BITS = 16;

    // Search limits
    localparam int         TABLE_LEN = 14;
    localparam logic [2:0] MAX_D     = 3'd7;
    localparam logic [7:0] MIN_P     = 8'd4;
    localparam logic [7:0] MAX_P     = 8'd130;
    localparam logic [7:0] MIN_Q     = 8'd3;
    localparam logic [7:0] MAX_Q     = 8'd129;

    // Reset value of the reference clock register (about 14.318 MHz)
    localparam logic [20:0] REF_RESET = 21'd938356;

    // Status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_UNREACH  = 2'd1;
    localparam logic [1:0] ST_NOPRESET = 2'd2;

    // Input word
    typedef struct packed {
        logic [22:0] target_freq;
        logic [23:0] vco_low;
        logic [23:0] vco_high;
    } t_in;

    // Result word
    typedef struct packed {
        logic [20:0] control_word;
        logic [1:0]  status;
    } t_out;

    // Divider status back to the sequencer
    typedef struct packed {
        logic       done;
        logic       sat;
        logic [7:0] quo;
    } t_div_res;

    // VCO preset boundaries in tenths of MHz
    function automatic logic [10:0] pds_edge(input logic [3:0] idx);
        logic [10:0] val;
        unique case (idx)
            4'd0:    val = 11'd500;
            4'd1:    val = 11'd510;
            4'd2:    val = 11'd532;
            4'd3:    val = 11'd585;
            4'd4:    val = 11'd607;
            4'd5:    val = 11'd644;
            4'd6:    val = 11'd668;
            4'd7:    val = 11'd735;
            4'd8:    val = 11'd756;
            4'd9:    val = 11'd809;
            4'd10:   val = 11'd832;
            4'd11:   val = 11'd915;
            4'd12:   val = 11'd1000;
            4'd13:   val = 11'd1200;
            default: val = 11'd0;
        endcase
        return val;
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/pds_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// pds_mul
// Shared 32 x 32 unsigned multiplier with a registered 64-bit product.
// ============================================================================
module pds_mul (
    input  wire logic        i_clk,
    input  wire logic [31:0] i_a,
    input  wire logic [31:0] i_b,
    output logic      [63:0] o_prod
);

    logic [63:0] r_prod;

    // Register the product for use in the next cycle
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule
`default_nettype wire

// File: rtl/core/pds_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// pds_div
// Restoring divider, one quotient bit per cycle, 8-bit quotient. Flags
// saturation when the quotient would not fit in 8 bits.
// ============================================================================
module pds_div
    import pds_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [32:0] i_dividend,
    input  wire logic [21:0] i_divisor,
    output t_div_res         o_res
);

    logic        r_busy;
    logic        r_done;
    logic        r_sat;
    logic [2:0]  r_cnt;
    logic [32:0] r_rem;
    logic [32:0] r_dsh;
    logic [7:0]  r_quo;
    logic        w_ge;

    assign w_ge = (r_rem >= r_dsh);

    // Load on start, then try one shifted divisor per cycle, subtracting it when it fits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= i_dividend;
                r_dsh  <= {4'b0, i_divisor, 7'b0};
                r_sat  <= (i_dividend >= {3'b0, i_divisor, 8'b0});
                r_quo  <= '0;
            end else if (r_busy) begin
                if (w_ge) begin
                    r_rem <= r_rem - r_dsh;
                end
                r_quo <= {r_quo[6:0], w_ge};
                r_dsh <= r_dsh >> 1;
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd7) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_res.done = r_done;
    assign o_res.sat  = r_sat;
    assign o_res.quo  = r_quo;

    // A new division never starts on top of a running one
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider restarted while busy");

    // Done follows the last step
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy) && !r_busy)
        else $error("divider done without a run");

endmodule
`default_nettype wire

// File: rtl/core/pll_divisor_search.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// pll_divisor_search
// Turns a target frequency and a VCO window into a PLL p/q/d control word:
// doubles to the window, scans q with one shared multiplier and a serial
// divider, keeps the best p/q by cross products, then looks up the preset.
// ============================================================================
// Operation: doubles the target up to MAX_D times towards the window floor,
//   then for each q tried (at most 127) runs the divider for p and makes up
//   to four passes through the shared multiplier, then walks the preset
//   boundaries and moves the result to the output register.
// Throughput: one word at a time; the next word is taken once the result
//   has moved to the output register.
// Reset: reference clock returns to 938356, sequencer idle, output empty.
// ============================================================================
module pll_divisor_search
    import pds_pkg::*;
#(
    parameter int PRESET_COUNT  = DEF_PRESET_COUNT,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire t_in         i_data,
    output logic             o_valid,
    input  wire logic        i_ready,
    output t_out             o_data,
    input  wire logic        i_cfg_we,
    input  wire logic [20:0] i_cfg_data
);

    localparam int          USED_COUNT = (PRESET_COUNT < TABLE_LEN) ? PRESET_COUNT
                                                                    : TABLE_LEN;
    localparam logic [3:0]  USED_IDX   = 4'(USED_COUNT);
    localparam logic [25:0] ONE_M1     = 26'((64'd1 << FRACTION_BITS) - 64'd1);
    localparam int          EDGE_W     = 11 + FRACTION_BITS;
    localparam int          CMP_W      = (EDGE_W > 28) ? EDGE_W : 28;

    typedef enum logic [3:0] {
        S_IDLE, S_DBL, S_RANGE, S_VQ, S_DIVGO, S_DIVW, S_NUM,
        S_X1, S_X2, S_CMP, S_NEXT, S_IDX, S_DONE
    } t_state;

    t_state      r_state, n_state;
    logic [20:0] r_ref;
    logic [29:0] r_vco, n_vco;
    logic [2:0]  r_d, n_d;
    logic [23:0] r_lo, n_lo;
    logic [23:0] r_hi, n_hi;
    logic [27:0] r_vco10, n_vco10;
    logic [7:0]  r_q, n_q;
    logic [7:0]  r_last, n_last;
    logic [31:0] r_vq, n_vq;
    logic [7:0]  r_p, n_p;
    logic [31:0] r_num, n_num;
    logic [63:0] r_lhs, n_lhs;
    logic [31:0] r_best_num, n_best_num;
    logic [31:0] r_best_den, n_best_den;
    logic [7:0]  r_best_p, n_best_p;
    logic [7:0]  r_best_q, n_best_q;
    logic        r_found, n_found;
    logic [3:0]  r_idx, n_idx;
    t_out        r_res, n_res;
    logic        r_out_valid, n_out_valid;
    t_out        r_out, n_out;

    logic [31:0]    w_mul_a, w_mul_b;
    logic [63:0]    w_prod;
    logic           w_div_start;
    logic [32:0]    w_dividend;
    t_div_res       w_div;
    logic [25:0]    w_ceil_sum;
    logic [25:0]    w_first_full;
    logic [23:0]    w_five_ref;
    logic [23:0]    w_last_full;
    logic [25:0]    w_first_cl;
    logic [7:0]     w_last_cl;
    logic [CMP_W-1:0] w_edge_scaled;

    // Reference clock register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref <= REF_RESET;
        end else if (i_cfg_we) begin
            r_ref <= i_cfg_data;
        end
    end

    // Shared arithmetic units
    pds_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    assign w_dividend = {1'b0, w_prod[31:0]} + {12'b0, r_ref};

    pds_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  ({r_ref, 1'b0}),
        .o_res      (w_div)
    );

    // q range from the reference clock
    assign w_ceil_sum   = {5'b0, r_ref} + ONE_M1;
    assign w_first_full = w_ceil_sum >> FRACTION_BITS;
    assign w_five_ref   = ({3'b0, r_ref} << 2) + {3'b0, r_ref};
    assign w_last_full  = w_five_ref >> FRACTION_BITS;
    assign w_first_cl   = (w_first_full < {18'b0, MIN_Q}) ? {18'b0, MIN_Q} : w_first_full;
    assign w_last_cl    = (w_last_full > {16'b0, MAX_Q}) ? MAX_Q : w_last_full[7:0];

    // Preset boundary scaled to the frequency format
    assign w_edge_scaled = CMP_W'(pds_edge(r_idx)) << FRACTION_BITS;

    // Sequencer next state
    always_comb begin
        n_state     = r_state;
        n_vco       = r_vco;
        n_d         = r_d;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_vco10     = r_vco10;
        n_q         = r_q;
        n_last      = r_last;
        n_vq        = r_vq;
        n_p         = r_p;
        n_num       = r_num;
        n_lhs       = r_lhs;
        n_best_num  = r_best_num;
        n_best_den  = r_best_den;
        n_best_p    = r_best_p;
        n_best_q    = r_best_q;
        n_found     = r_found;
        n_idx       = r_idx;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        w_mul_a     = '0;
        w_mul_b     = '0;
        w_div_start = 1'b0;

        // Drop the output word once taken
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_vco      = {7'b0, i_data.target_freq};
                    n_lo       = i_data.vco_low;
                    n_hi       = i_data.vco_high;
                    n_d        = '0;
                    n_found    = 1'b0;
                    n_best_num = 32'd1;
                    n_best_den = 32'd1;
                    n_best_p   = '0;
                    n_best_q   = '0;
                    n_idx      = '0;
                    n_state    = S_DBL;
                end
            end
            S_DBL: begin
                // Double up to the window floor
                if (r_vco < {6'b0, r_lo} && r_d < MAX_D) begin
                    n_vco = r_vco << 1;
                    n_d   = r_d + 3'd1;
                end else begin
                    n_state = S_RANGE;
                end
            end
            S_RANGE: begin
                n_vco10 = {r_vco[24:0], 3'b0} + {2'b0, r_vco[24:0], 1'b0};
                n_q     = w_first_cl[7:0];
                n_last  = w_last_cl;
                if (r_vco < {6'b0, r_lo} || r_vco > {6'b0, r_hi}) begin
                    n_res   = '{control_word: '0, status: ST_UNREACH};
                    n_state = S_DONE;
                end else if (r_ref == '0 || w_first_cl > {18'b0, w_last_cl}) begin
                    n_state = S_IDX;
                end else begin
                    n_state = S_VQ;
                end
            end
            S_VQ: begin
                w_mul_a = {8'b0, r_vco[23:0]};
                w_mul_b = {24'b0, r_q};
                n_state = S_DIVGO;
            end
            S_DIVGO: begin
                // Start p = (vq + ref) / (2 ref)
                n_vq        = w_prod[31:0];
                w_div_start = 1'b1;
                n_state     = S_DIVW;
            end
            S_DIVW: begin
                if (w_div.done) begin
                    n_p = w_div.quo;
                    if (w_div.sat || w_div.quo > MAX_P) begin
                        n_state = S_IDX;
                    end else if (w_div.quo < MIN_P || r_vq == '0) begin
                        n_state = S_NEXT;
                    end else begin
                        w_mul_a = {10'b0, r_ref, 1'b0};
                        w_mul_b = {24'b0, w_div.quo};
                        n_state = S_NUM;
                    end
                end
            end
            S_NUM: begin
                n_num   = (w_prod[31:0] > r_vq) ? (w_prod[31:0] - r_vq)
                                                : (r_vq - w_prod[31:0]);
                n_state = S_X1;
            end
            S_X1: begin
                w_mul_a = r_num;
                w_mul_b = r_best_den;
                n_state = S_X2;
            end
            S_X2: begin
                n_lhs   = w_prod;
                w_mul_a = r_best_num;
                w_mul_b = r_vq;
                n_state = S_CMP;
            end
            S_CMP: begin
                // Keep the pair with the smaller relative error
                if (r_lhs < w_prod) begin
                    n_best_num = r_num;
                    n_best_den = r_vq;
                    n_best_p   = r_p;
                    n_best_q   = r_q;
                    n_found    = 1'b1;
                end
                if (n_found && n_best_num == '0) begin
                    n_state = S_IDX;
                end else begin
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                if (r_q == r_last) begin
                    n_state = S_IDX;
                end else begin
                    n_q     = r_q + 8'd1;
                    n_state = S_VQ;
                end
            end
            S_IDX: begin
                // Walk the preset boundaries
                if (!r_found) begin
                    n_res   = '{control_word: '0, status: ST_UNREACH};
                    n_state = S_DONE;
                end else if (r_idx == USED_IDX) begin
                    n_res   = '{control_word: '0, status: ST_NOPRESET};
                    n_state = S_DONE;
                end else if (w_edge_scaled > CMP_W'(r_vco10)) begin
                    if (r_idx == '0) begin
                        n_res = '{control_word: '0, status: ST_NOPRESET};
                    end else begin
                        n_res.control_word = {r_idx - 4'd1, 7'(r_best_p - 8'd3), r_d,
                                              7'(r_best_q - 8'd2)};
                        n_res.status       = ST_OK;
                    end
                    n_state = S_DONE;
                end else begin
                    n_idx = r_idx + 4'd1;
                end
            end
            S_DONE: begin
                // Hand the word to the output register once it is free
                if (!r_out_valid || i_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_found     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_found     <= n_found;
        end
        r_vco      <= n_vco;
        r_d        <= n_d;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_vco10    <= n_vco10;
        r_q        <= n_q;
        r_last     <= n_last;
        r_vq       <= n_vq;
        r_p        <= n_p;
        r_num      <= n_num;
        r_lhs      <= n_lhs;
        r_best_num <= n_best_num;
        r_best_den <= n_best_den;
        r_best_p   <= n_best_p;
        r_best_q   <= n_best_q;
        r_idx      <= n_idx;
        r_res      <= n_res;
        r_out      <= n_out;
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // An error word carries no control bits
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status != ST_OK) |-> (r_out.control_word == '0))
        else $error("error word with nonzero control word");

    // A kept pair always has p in range
    a_best_p: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_found |-> (r_best_p >= MIN_P && r_best_p <= MAX_P))
        else $error("kept p out of range");

    // q stays within its limits while scanning
    a_q_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_VQ) |-> (r_q >= MIN_Q && r_q <= MAX_Q))
        else $error("q out of range");

    // Divider results arrive only while the sequencer waits for them
    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div.done |-> (r_state == S_DIVW))
        else $error("divider done outside wait state");

endmodule
`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for the PLL divisor search. Feeds target frequency
// and VCO window words under random idling on both sides, predicts each
// control word and status in the bench, and steps the reference clock
// register through its extremes and random settings between phases.
// ============================================================================
module tb;
    import pds_pkg::*;

    localparam int          MHZ        = 65536;
    localparam int          WDOG_LIMIT = 20000;
    localparam int          PHASES     = 11;
    localparam int          PRESETS    = (DEF_PRESET_COUNT < TABLE_LEN) ?
                                         DEF_PRESET_COUNT : TABLE_LEN;

    // Scoreboard: predicts the control word of each accepted request
    class pll_word_scoreboard;
        logic [20:0] ref_clk;
        t_out        expected_q[$];
        int          errors;

        function new();
            ref_clk = REF_RESET;
            errors  = 0;
        endfunction

        function void set_reference(logic [20:0] value);
            ref_clk = value;
        endfunction

        // VCO preset boundaries in tenths of MHz
        function logic [63:0] boundary_tenths(int idx);
            case (idx)
                0:       return 64'd500;
                1:       return 64'd510;
                2:       return 64'd532;
                3:       return 64'd585;
                4:       return 64'd607;
                5:       return 64'd644;
                6:       return 64'd668;
                7:       return 64'd735;
                8:       return 64'd756;
                9:       return 64'd809;
                10:      return 64'd832;
                11:      return 64'd915;
                12:      return 64'd1000;
                default: return 64'd1200;
            endcase
        endfunction

        function t_out predict_word(t_in w);
            t_out        res;
            logic [63:0] rc, vco, first_q, last_q, q, vq, p, prod, num;
            logic [63:0] best_num, best_den, best_p, best_q, pm3, qm2, idx_v;
            logic [63:0] d_v;
            bit          found;
            int          idx;
            res        = '0;
            res.status = ST_UNREACH;
            rc         = 64'(ref_clk);
            vco        = 64'(w.target_freq);
            d_v        = 0;
            found      = 0;
            best_num   = 1;
            best_den   = 1;
            best_p     = 0;
            best_q     = 0;
            // double up to the window
            while (vco < 64'(w.vco_low) && d_v < 64'(MAX_D)) begin
                vco = vco << 1;
                d_v = d_v + 1;
            end
            if (vco < 64'(w.vco_low) || vco > 64'(w.vco_high))
                return res;
            first_q = (rc + (64'd1 << DEF_FRACTION_BITS) - 1) >> DEF_FRACTION_BITS;
            if (first_q < 64'(MIN_Q))
                first_q = 64'(MIN_Q);
            last_q = (64'd5 * rc) >> DEF_FRACTION_BITS;
            if (last_q > 64'(MAX_Q))
                last_q = 64'(MAX_Q);
            // scan q, keep the smallest relative error, stop on an exact hit
            if (rc != 0) begin
                for (q = first_q; q <= last_q; q++) begin
                    vq = vco * q;
                    p  = (vq + rc) / (64'd2 * rc);
                    if (p < 64'(MIN_P))
                        continue;
                    if (p > 64'(MAX_P))
                        break;
                    if (vq == 0)
                        continue;
                    prod = 64'd2 * rc * p;
                    num  = (prod > vq) ? prod - vq : vq - prod;
                    if (num * best_den < best_num * vq) begin
                        best_num = num;
                        best_den = vq;
                        best_p   = p;
                        best_q   = q;
                        found    = 1;
                    end
                    if (found && best_num == 0)
                        break;
                end
            end
            if (!found)
                return res;
            // preset lookup
            for (idx = 0; idx < PRESETS; idx++) begin
                if ((boundary_tenths(idx) << DEF_FRACTION_BITS) > 64'd10 * vco)
                    break;
            end
            if (idx == 0 || idx >= PRESETS) begin
                res.status = ST_NOPRESET;
                return res;
            end
            idx_v = 64'(idx - 1);
            pm3   = best_p - 3;
            qm2   = best_q - 2;
            res.control_word = {idx_v[3:0], pm3[6:0], d_v[2:0], qm2[6:0]};
            res.status       = ST_OK;
            return res;
        endfunction

        function void note_input(t_in w);
            expected_q.push_back(predict_word(w));
        endfunction

        function void check_result(t_out got);
            t_out want;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: word %06h status %0d",
                             got.control_word, got.status);
                return;
            end
            want = expected_q.pop_front();
            if (got.control_word !== want.control_word || got.status !== want.status) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected word %06h status %0d, got word %06h status %0d",
                             want.control_word, want.status, got.control_word, got.status);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_valid    = 1'b0;
    logic        o_ready;
    t_in         i_data     = '0;
    logic        o_valid;
    logic        i_ready    = 1'b0;
    t_out        o_data;
    logic        i_cfg_we   = 1'b0;
    logic [20:0] i_cfg_data = '0;

    pll_word_scoreboard sb;
    int                 idle_cycles = 0;

    pll_divisor_search uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data     (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    // Clock
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Hold valid until the word is taken; gap of zero keeps valid high
    task automatic send_word(input t_in w, input int gap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= w;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_input(w);
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_reference(input logic [20:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.set_reference(value);
    endtask

    function automatic t_in make_word(int unsigned freq, int unsigned lo, int unsigned hi);
        t_in w;
        w.target_freq = freq[22:0];
        w.vco_low     = lo[23:0];
        w.vco_high    = hi[23:0];
        return w;
    endfunction

    // Mostly reachable windows with random content, some noise and broken windows
    function automatic t_in random_word();
        logic [31:0] lo, hi, v, a, b, c;
        int          pick, shift;
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            a = $urandom;
            b = $urandom;
            c = $urandom;
            return make_word(a[22:0], b[23:0], c[23:0]);
        end
        lo    = $urandom_range(30 * MHZ, 125 * MHZ);
        hi    = lo + $urandom_range(0, 60 * MHZ);
        if (hi > 32'hFFFFFF)
            hi = 32'hFFFFFF;
        shift = $urandom_range(0, 7);
        v     = $urandom_range(lo, hi);
        v     = v >> shift;
        if (v > 32'h7FFFFF)
            v = 32'h7FFFFF;
        if (pick < 25) begin
            if ($urandom_range(0, 1) == 0)
                hi = lo - $urandom_range(1, MHZ);
            else
                v = v >> $urandom_range(8, 12);
        end
        return make_word(v, lo, hi);
    endfunction

    function automatic int sender_gap(int n);
        return (n % 100 < 25) ? 0 : $urandom_range(0, 19);
    endfunction

    // Extremes and special cases at the reset reference clock
    task automatic run_directed();
        t_in dir_q[$];
        int  n;
        dir_q.push_back(make_word(0, 0, 0));
        dir_q.push_back(make_word(23'h7FFFFF, 0, 24'hFFFFFF));
        dir_q.push_back(make_word(23'h7FFFFF, 24'hFFFFFF, 24'hFFFFFF));
        dir_q.push_back(make_word(1, 24'hFFFFFF, 24'hFFFFFF));
        dir_q.push_back(make_word(100 * MHZ, 50 * MHZ, 120 * MHZ));
        dir_q.push_back(make_word(25 * MHZ, 50 * MHZ, 120 * MHZ));
        dir_q.push_back(make_word((100 * MHZ) >> 7, 100 * MHZ, 120 * MHZ));
        dir_q.push_back(make_word(4691780, 50 * MHZ, 120 * MHZ));
        dir_q.push_back(make_word(40 * MHZ, 40 * MHZ, 120 * MHZ));
        dir_q.push_back(make_word(1 * MHZ, 1 * MHZ, 2 * MHZ));
        dir_q.push_back(make_word(5000000, 5000000, 5000000));
        dir_q.push_back(make_word(5000001, 0, 5000000));
        dir_q.push_back(make_word(50 * MHZ, 50 * MHZ, 8000000));
        dir_q.push_back(make_word(50 * MHZ - 1, 0, 8000000));
        dir_q.push_back(make_word(120 * MHZ - 1, 0, 8000000));
        dir_q.push_back(make_word(120 * MHZ, 0, 8000000));
        dir_q.push_back(make_word(7000000, 24'h800000, 24'hFFFFFF));
        dir_q.push_back(make_word(3500000, 3000000, 24'h7FFFFF));
        for (n = 0; n < dir_q.size(); n++)
            send_word(dir_q[n], sender_gap(n + 50));
    endtask

    // Sink: random stalls, with stretches of no stalls
    initial begin
        int seen;
        int gap;
        seen = 0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            gap = (seen % 128 < 32) ? 0 : $urandom_range(0, 19);
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            sb.check_result(o_data);
            seen++;
        end
    end

    // Main sequence: one reference clock setting per phase
    initial begin
        int          k;
        int          n;
        int          count;
        logic [20:0] ref_val;
        sb = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (k = 0; k < PHASES; k++) begin
            case (k)
                0:       begin ref_val = REF_RESET;    count = 150; end
                1:       begin ref_val = 21'd65536;    count = 150; end
                2:       begin ref_val = 21'd1703936;  count = 150; end
                3:       begin ref_val = 21'd0;        count = 30;  end
                4:       begin ref_val = 21'd1;        count = 30;  end
                5:       begin ref_val = 21'h1FFFFF;   count = 100; end
                default: begin
                    ref_val = 21'($urandom_range(65536, 1703936));
                    count   = 120;
                end
            endcase
            // register changes only with nothing in flight
            wait_drained();
            write_reference(ref_val);
            if (k == 0)
                run_directed();
            for (n = 0; n < count; n++)
                send_word(random_word(), sender_gap(n));
            i_valid <= 1'b0;
        end
        wait_drained();
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/pds_pkg.sv
rtl/core/pds_mul.sv
rtl/core/pds_div.sv
rtl/core/pll_divisor_search.sv
tb/tb.sv
